// ----- sv/cds_pkg.sv -----
// Shared types, constants and helper functions for the clock display scanner.
package cds_pkg;

   localparam int NUM_DIGITS_DEF = 4;
   localparam int BUF_DIGITS     = 4;
   localparam int BUF_IDX_W      = $clog2(BUF_DIGITS);
   localparam int DIGIT_EN_W     = BUF_DIGITS;
   localparam int MATRIX_SIZE    = 8;
   localparam int PERIOD_W       = 8;
   localparam int PATTERN_W      = MATRIX_SIZE * MATRIX_SIZE;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = PATTERN_W;

   localparam logic [PERIOD_W-1:0]  DIGIT_PERIOD_RST   = 8'd25;
   localparam logic [PERIOD_W-1:0]  SECOND_PERIOD_RST  = 8'd100;
   localparam logic [PERIOD_W-1:0]  COLUMN_PERIOD_RST  = 8'd2;
   localparam logic [PATTERN_W-1:0] PATTERN_RST        = 64'h0066_667E_6666_3C18;

   localparam logic [5:0] SECONDS_RST = 6'd50;
   localparam logic [5:0] MINUTES_RST = 6'd8;
   localparam logic [4:0] HOURS_RST   = 5'd15;
   localparam logic [5:0] LAST_SECOND = 6'd59;
   localparam logic [5:0] LAST_MINUTE = 6'd59;
   localparam logic [4:0] LAST_HOUR   = 5'd23;
   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
   localparam logic [4:0] HOURS_PER_DAY      = 5'd24;

   // Buffer after reset shows 15:08; entry 0 sits in the lowest nibble.
   localparam logic [BUF_DIGITS-1:0][3:0] DIGITS_RST = {4'd8, 4'd0, 4'd5, 4'd1};

   localparam int REQ_DATA_W   = 8;
   localparam int RSP_FIELDS_W = 45;
   localparam int RSP_DATA_W   = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIGIT_PERIOD   = 2'd0,
      CSR_SECOND_PERIOD  = 2'd1,
      CSR_COLUMN_PERIOD  = 2'd2,
      CSR_MATRIX_PATTERN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic digit;
      logic second;
      logic column;
   } fire_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       dot;
   } time_type;

   typedef struct packed {
      logic [6:0]            segments;
      logic [DIGIT_EN_W-1:0] digit_en;
      logic [7:0]            rows;
      logic [7:0]            col_en;
   } scan_type;

   // Active-low segment drive for one decimal digit; codes above nine go dark.
   function automatic logic [6:0] seg_code(input logic [3:0] value);
      logic [6:0] lit;
      case (value)
         4'd0:    lit = 7'h3F;
         4'd1:    lit = 7'h06;
         4'd2:    lit = 7'h5B;
         4'd3:    lit = 7'h4F;
         4'd4:    lit = 7'h66;
         4'd5:    lit = 7'h6D;
         4'd6:    lit = 7'h7D;
         4'd7:    lit = 7'h07;
         4'd8:    lit = 7'h7F;
         4'd9:    lit = 7'h6F;
         default: lit = 7'h00;
      endcase
      return ~lit;
   endfunction

   // Tens digit of a value below sixty, by comparison.
   function automatic logic [3:0] tens_of(input logic [5:0] value);
      logic [3:0] tens;
      if (value >= 6'd50) begin
         tens = 4'd5;
      end else if (value >= 6'd40) begin
         tens = 4'd4;
      end else if (value >= 6'd30) begin
         tens = 4'd3;
      end else if (value >= 6'd20) begin
         tens = 4'd2;
      end else if (value >= 6'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      return tens;
   endfunction

   // Units digit of a value below sixty; the product is formed at six bits.
   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [5:0] rest;
      rest = value - 6'(tens_of(value)) * 6'd10;
      return rest[3:0];
   endfunction

endpackage

// ----- sv/cds_divider.sv -----
// Reloading countdown divider that fires once every period steps.
module cds_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [cds_pkg::PERIOD_W-1:0]  period,
   input  logic [cds_pkg::PERIOD_W-1:0]  reload_init,
   output logic                          fire
);

   logic [cds_pkg::PERIOD_W-1:0] count_ff, count_in;

   // A count of one or zero fires and reloads, so period zero acts as one.
   assign fire = step && (count_ff <= cds_pkg::PERIOD_W'(1));

   always_comb begin
      if (fire) begin
         count_in = period;
      end else if (step) begin
         count_in = count_ff - cds_pkg::PERIOD_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= reload_init;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/cds_clock.sv -----
// Time-of-day counters, hour and minute digit buffer, and the blinking dot.
module cds_clock (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   output cds_pkg::time_type                      time_next,
   output logic [cds_pkg::BUF_DIGITS-1:0][3:0]    digits
);

   logic [4:0] hours_ff, hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic       dot_ff, dot_in;
   logic [cds_pkg::BUF_DIGITS-1:0][3:0] digits_ff, digits_in;

   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      dot_in     = dot_ff;
      digits_in  = digits_ff;
      if (advance) begin
         dot_in = ~dot_ff;
         if (seconds_ff >= cds_pkg::LAST_SECOND) begin
            seconds_in = '0;
            if (minutes_ff >= cds_pkg::LAST_MINUTE) begin
               minutes_in = '0;
               hours_in   = (hours_ff >= cds_pkg::LAST_HOUR) ? '0 : hours_ff + 5'd1;
            end else begin
               minutes_in = minutes_ff + 6'd1;
            end
         end else begin
            seconds_in = seconds_ff + 6'd1;
         end
         digits_in[0] = cds_pkg::tens_of({1'b0, hours_in});
         digits_in[1] = cds_pkg::units_of({1'b0, hours_in});
         digits_in[2] = cds_pkg::tens_of(minutes_in);
         digits_in[3] = cds_pkg::units_of(minutes_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= cds_pkg::HOURS_RST;
         minutes_ff <= cds_pkg::MINUTES_RST;
         seconds_ff <= cds_pkg::SECONDS_RST;
         dot_ff     <= 1'b0;
         digits_ff  <= cds_pkg::DIGITS_RST;
      end else begin
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         dot_ff     <= dot_in;
         digits_ff  <= digits_in;
      end
   end

   assign time_next.hours   = hours_in;
   assign time_next.minutes = minutes_in;
   assign time_next.seconds = seconds_in;
   assign time_next.dot     = dot_in;
   // The scan reads the buffer as it stood before this step.
   assign digits            = digits_ff;

endmodule

// ----- sv/cds_scan.sv -----
// Seven-segment digit scan and LED matrix column scan with held pin registers.
module cds_scan #(
   parameter int NUM_DIGITS = cds_pkg::NUM_DIGITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cds_pkg::fire_type                      fires,
   input  logic [cds_pkg::BUF_DIGITS-1:0][3:0]    digits,
   input  logic [cds_pkg::PATTERN_W-1:0]          pattern,
   output cds_pkg::scan_type                      scan_next
);

   localparam int DIDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [DIDX_W-1:0] LAST_DIGIT = DIDX_W'(NUM_DIGITS - 1);
   localparam int CIDX_W = $clog2(cds_pkg::MATRIX_SIZE);

   cds_pkg::scan_type  scan_ff, scan_in;
   logic [DIDX_W-1:0]  digit_idx_ff, digit_idx_in;
   logic [CIDX_W-1:0]  column_idx_ff, column_idx_in;
   logic [3:0]         digit_idx_ext;
   logic [cds_pkg::MATRIX_SIZE-1:0][cds_pkg::MATRIX_SIZE-1:0] pattern_rows;

   assign digit_idx_ext = 4'(digit_idx_ff);
   assign pattern_rows  = pattern;

   always_comb begin
      scan_in       = scan_ff;
      digit_idx_in  = digit_idx_ff;
      column_idx_in = column_idx_ff;
      if (fires.digit) begin
         // Selects past the buffer blank all digits and keep the segments.
         if (digit_idx_ext < 4'(cds_pkg::BUF_DIGITS)) begin
            scan_in.digit_en = ~(cds_pkg::DIGIT_EN_W'(1)
                                 << digit_idx_ext[cds_pkg::BUF_IDX_W-1:0]);
            scan_in.segments = cds_pkg::seg_code(
                                  digits[digit_idx_ext[cds_pkg::BUF_IDX_W-1:0]]);
         end else begin
            scan_in.digit_en = '1;
         end
         digit_idx_in = (digit_idx_ff == LAST_DIGIT) ? '0 : digit_idx_ff + DIDX_W'(1);
      end
      if (fires.column) begin
         for (int r = 0; r < cds_pkg::MATRIX_SIZE; r++) begin
            scan_in.rows[r] = ~pattern_rows[r][column_idx_ff];
         end
         scan_in.col_en = ~(8'(1) << column_idx_ff);
         column_idx_in  = column_idx_ff + CIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         digit_idx_ff  <= '0;
         column_idx_ff <= '0;
      end else begin
         scan_ff       <= scan_in;
         digit_idx_ff  <= digit_idx_in;
         column_idx_ff <= column_idx_in;
      end
   end

   assign scan_next = scan_in;

endmodule

// ----- sv/cds_skid.sv -----
// Two-entry result buffer that keeps input acceptance off the result ready path.
module cds_skid (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [cds_pkg::RSP_DATA_W-1:0]  in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [cds_pkg::RSP_DATA_W-1:0]  out_data
);

   logic                            main_valid_ff, main_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic [cds_pkg::RSP_DATA_W-1:0]  main_data_ff, main_data_in;
   logic [cds_pkg::RSP_DATA_W-1:0]  skid_data_ff, skid_data_in;
   logic                            push, pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ----- sv/clock_display_scanner_top.sv -----
// Top level of the clock display scanner: registers, dividers, clock, scan and result buffer.
//
//   Channel   Dir   Handshake              Payload
//   req_      in    req_tvalid/req_tready  req_tdata[0] tick
//   rsp_      out   rsp_tvalid/rsp_tready  rsp_tdata pin drive and time of day
//   csr_      in    csr_we (no wait)       csr_index, csr_wdata
//
// Every accepted request beat yields exactly one response beat. The state update
// for a beat is one short pass of logic from the held counters to the registers,
// so a beat is taken in every cycle while the result buffer has room; its response is registered.
// The result buffer holds two beats: the request side stalls only when both are
// full, and that stall depends on registered state, not on rsp_tready.
// Reset is synchronous and active high; it restores the periods, the pattern,
// the time 15:08:50 with digits 1508, and clears the scan and pin registers.
// A beat with tick low changes nothing and repeats the held pin state.
module clock_display_scanner_top #(
   parameter int NUM_DIGITS = cds_pkg::NUM_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, from bit 0: tick, then seven zero bits
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cds_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata, from bit 0: segment_lines[6:0], digit_enables[10:7],
   // row_lines[18:11], column_enables[26:19], dot_line[27], hours_now[32:28],
   // minutes_now[38:33], seconds_now[44:39], zeros[47:45]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cds_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [cds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [cds_pkg::PERIOD_W-1:0]    digit_period_ff, second_period_ff, column_period_ff;
   logic [cds_pkg::PATTERN_W-1:0]   pattern_ff;
   logic                            req_accept;
   logic                            tick_step;
   cds_pkg::fire_type               fires;
   cds_pkg::time_type               time_next;
   cds_pkg::scan_type               scan_next;
   logic [cds_pkg::BUF_DIGITS-1:0][3:0] digits;
   logic [cds_pkg::RSP_DATA_W-1:0]  rsp_data_in;

   // Configuration registers; a write takes effect at the next reload of a divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_period_ff  <= cds_pkg::DIGIT_PERIOD_RST;
         second_period_ff <= cds_pkg::SECOND_PERIOD_RST;
         column_period_ff <= cds_pkg::COLUMN_PERIOD_RST;
         pattern_ff       <= cds_pkg::PATTERN_RST;
      end else if (csr_we) begin
         case (cds_pkg::csr_index_type'(csr_index))
            cds_pkg::CSR_DIGIT_PERIOD:
               digit_period_ff  <= csr_wdata[cds_pkg::PERIOD_W-1:0];
            cds_pkg::CSR_SECOND_PERIOD:
               second_period_ff <= csr_wdata[cds_pkg::PERIOD_W-1:0];
            cds_pkg::CSR_COLUMN_PERIOD:
               column_period_ff <= csr_wdata[cds_pkg::PERIOD_W-1:0];
            cds_pkg::CSR_MATRIX_PATTERN:
               pattern_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_accept = req_tvalid && req_tready;
   assign tick_step  = req_accept && req_tdata[0];

   // The three dividers count the same ticks; on a shared tick the digit scan
   // still reads the buffer from before the clock advance.
   cds_divider u_digit_div (
      .clock       (clock),
      .reset       (reset),
      .step        (tick_step),
      .period      (digit_period_ff),
      .reload_init (cds_pkg::DIGIT_PERIOD_RST),
      .fire        (fires.digit)
   );

   cds_divider u_second_div (
      .clock       (clock),
      .reset       (reset),
      .step        (tick_step),
      .period      (second_period_ff),
      .reload_init (cds_pkg::SECOND_PERIOD_RST),
      .fire        (fires.second)
   );

   cds_divider u_column_div (
      .clock       (clock),
      .reset       (reset),
      .step        (tick_step),
      .period      (column_period_ff),
      .reload_init (cds_pkg::COLUMN_PERIOD_RST),
      .fire        (fires.column)
   );

   cds_clock u_clock (
      .clock     (clock),
      .reset     (reset),
      .advance   (fires.second),
      .time_next (time_next),
      .digits    (digits)
   );

   cds_scan #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .fires     (fires),
      .digits    (digits),
      .pattern   (pattern_ff),
      .scan_next (scan_next)
   );

   // The response carries the state as it stands after the accepted beat.
   assign rsp_data_in = {
      (cds_pkg::RSP_DATA_W - cds_pkg::RSP_FIELDS_W)'(0),
      time_next.seconds,
      time_next.minutes,
      time_next.hours,
      time_next.dot,
      scan_next.col_en,
      scan_next.rows,
      scan_next.digit_en,
      scan_next.segments
   };

   cds_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (rsp_data_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // The time of day never leaves its range.
   a_time_range : assert property (@(posedge clock) disable iff (reset)
      (time_next.seconds < cds_pkg::SECONDS_PER_MINUTE) &&
      (time_next.minutes < cds_pkg::MINUTES_PER_HOUR) &&
      (time_next.hours < cds_pkg::HOURS_PER_DAY))
      else $error("time of day out of range");

   // A stalled request side means the buffer already holds a result.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with an empty result buffer");

   // Every accepted beat leaves a response waiting in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted beat produced no response");

   // Without a tick no divider may fire.
   a_no_tick_quiet : assert property (@(posedge clock) disable iff (reset)
      !tick_step |-> (fires == '0))
      else $error("divider fired without a tick");

endmodule

// ----- verif/clock_scan_pred_pkg.sv -----
// Scoreboard class that predicts and checks the response beats of the clock display scanner.
`timescale 1ns / 100ps

package clock_scan_pred_pkg;

   // One response beat, laid out exactly as rsp_tdata[44:0].
   typedef struct packed {
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic       dot;
      logic [7:0] col_en;
      logic [7:0] rows;
      logic [3:0] digit_en;
      logic [6:0] segments;
   } pin_beat_type;

   class display_scoreboard_type;
      logic [7:0]  digit_period, second_period, column_period;
      logic [63:0] pattern;
      logic [7:0]  digit_cnt, second_cnt, column_cnt;
      logic [5:0]  seconds, minutes;
      logic [4:0]  hours;
      logic [3:0]  digits [4];
      logic [1:0]  digit_sel;
      logic [2:0]  column_sel;
      logic [6:0]  seg_q;
      logic [3:0]  digit_en_q;
      logic [7:0]  rows_q, col_en_q;
      logic        dot_q;
      pin_beat_type expected_pins [$];
      int          errors;
      int          beats_checked;
      int          midnights;

      function new();
         restart();
      endfunction

      function void restart();
         digit_period  = cds_pkg::DIGIT_PERIOD_RST;
         second_period = cds_pkg::SECOND_PERIOD_RST;
         column_period = cds_pkg::COLUMN_PERIOD_RST;
         pattern       = cds_pkg::PATTERN_RST;
         digit_cnt     = digit_period;
         second_cnt    = second_period;
         column_cnt    = column_period;
         seconds       = 6'd50;
         minutes       = 6'd8;
         hours         = 5'd15;
         digits        = '{4'd1, 4'd5, 4'd0, 4'd8};
         digit_sel     = '0;
         column_sel    = '0;
         seg_q         = '0;
         digit_en_q    = '0;
         rows_q        = '0;
         col_en_q      = '0;
         dot_q         = 1'b0;
         expected_pins.delete();
         errors        = 0;
         beats_checked = 0;
         midnights     = 0;
      endfunction

      function void write_register(cds_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            cds_pkg::CSR_DIGIT_PERIOD:   digit_period  = value[7:0];
            cds_pkg::CSR_SECOND_PERIOD:  second_period = value[7:0];
            cds_pkg::CSR_COLUMN_PERIOD:  column_period = value[7:0];
            cds_pkg::CSR_MATRIX_PATTERN: pattern       = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      // Common-anode drive: a cleared bit lights the segment.
      function logic [6:0] dark_code(logic [3:0] value);
         case (value)
            4'd0:    return 7'h40;
            4'd1:    return 7'h79;
            4'd2:    return 7'h24;
            4'd3:    return 7'h30;
            4'd4:    return 7'h19;
            4'd5:    return 7'h12;
            4'd6:    return 7'h02;
            4'd7:    return 7'h78;
            4'd8:    return 7'h00;
            4'd9:    return 7'h10;
            default: return 7'h7F;
         endcase
      endfunction

      function void advance_clock();
         seconds = seconds + 6'd1;
         if (seconds >= 6'd60) begin
            seconds = '0;
            minutes = minutes + 6'd1;
         end
         if (minutes >= 6'd60) begin
            minutes = '0;
            hours   = hours + 5'd1;
         end
         if (hours >= 5'd24) begin
            hours = '0;
            midnights++;
         end
         digits[0] = 4'(hours / 5'd10);
         digits[1] = 4'(hours % 5'd10);
         digits[2] = 4'(minutes / 6'd10);
         digits[3] = 4'(minutes % 6'd10);
         dot_q = ~dot_q;
      endfunction

      // Updates the state for one accepted request beat and queues its response.
      function void note_tick(logic tick);
         bit           fire_digit, fire_second, fire_column;
         pin_beat_type beat;
         if (tick) begin
            fire_digit  = digit_cnt <= 8'd1;
            digit_cnt   = fire_digit ? digit_period : digit_cnt - 8'd1;
            fire_second = second_cnt <= 8'd1;
            second_cnt  = fire_second ? second_period : second_cnt - 8'd1;
            fire_column = column_cnt <= 8'd1;
            column_cnt  = fire_column ? column_period : column_cnt - 8'd1;
            // The digit is scanned before the buffer is refreshed on a shared tick.
            if (fire_digit) begin
               digit_en_q = ~(4'b0001 << digit_sel);
               seg_q      = dark_code(digits[digit_sel]);
               digit_sel  = digit_sel + 2'd1;
            end
            if (fire_second) begin
               advance_clock();
            end
            if (fire_column) begin
               for (int r = 0; r < 8; r++) begin
                  rows_q[r] = ~pattern[8 * r + column_sel];
               end
               col_en_q   = ~(8'h01 << column_sel);
               column_sel = column_sel + 3'd1;
            end
         end
         beat.segments = seg_q;
         beat.digit_en = digit_en_q;
         beat.rows     = rows_q;
         beat.col_en   = col_en_q;
         beat.dot      = dot_q;
         beat.hours    = hours;
         beat.minutes  = minutes;
         beat.seconds  = seconds;
         expected_pins.push_back(beat);
      endfunction

      // Only the first few dozen mismatches are printed; all of them are counted.
      task report(string what);
         errors++;
         if (errors <= 40) begin
            $display("%0t ns MISMATCH at response beat %0d: %s", $time, beats_checked, what);
         end
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
         end
      endtask

      task check_beat(logic [47:0] data);
         pin_beat_type got, want;
         got = data[44:0];
         if (expected_pins.size() == 0) begin
            report("response beat arrived with nothing expected");
            return;
         end
         want = expected_pins.pop_front();
         beats_checked++;
         compare_field("segment_lines", got.segments, want.segments);
         compare_field("digit_enables", got.digit_en, want.digit_en);
         compare_field("row_lines", got.rows, want.rows);
         compare_field("column_enables", got.col_en, want.col_en);
         compare_field("dot_line", got.dot, want.dot);
         compare_field("hours_now", got.hours, want.hours);
         compare_field("minutes_now", got.minutes, want.minutes);
         compare_field("seconds_now", got.seconds, want.seconds);
         compare_field("padding", data[47:45], 3'b000);
      endtask
   endclass

endpackage

// ----- verif/tb.sv -----
// Self-checking testbench for the clock display scanner top level.
`timescale 1ns / 100ps

module tb;

   // Each random phase runs this many request beats under one register setting.
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BEATS   = 110;
   // Bound on the wait for outstanding responses before a register write.
   localparam int DRAIN_LIMIT   = 2000;
   // Beats in the closing run with one clock second per tick.
   localparam int FAST_BEATS    = 100;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cds_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [cds_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_we     = 1'b0;
   cds_pkg::csr_index_type          csr_index  = cds_pkg::CSR_DIGIT_PERIOD;
   logic [cds_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // When set, both the request side and the response side insert idle bursts.
   bit idle_on     = 1'b0;
   int stall_left  = 0;
   int settings_used = 0;
   int ticks_sent  = 0;

   clock_scan_pred_pkg::display_scoreboard_type scoreboard = new();

   clock_display_scanner_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both channels are sampled at the rising edge, before the block's own
   // register updates land. The request beat is noted first so that its
   // expectation is already queued should a response ever arrive in the same
   // cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            scoreboard.note_tick(req_tdata[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            scoreboard.check_beat(rsp_tdata);
         end
      end
   end

   // Response backpressure: while idling is enabled a stall starts now and then;
   // otherwise the receiver is always ready.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one request beat and holds it until accepted. Entered and left at
   // a falling edge. tvalid stays high into the next beat unless a gap is
   // taken, so it is never lowered and raised within one step.
   task automatic send_tick(logic tick);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cds_pkg::REQ_DATA_W - 1){1'b0}}, tick};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (tick) begin
         ticks_sent++;
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   // Stops offering beats and waits until every expected response has been
   // checked, and then until the block is surely idle.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT) begin
         scoreboard.report("responses still missing after the drain limit");
      end
      repeat (4) @(negedge clock);
   endtask

   // One register write; the scoreboard copy is updated at once since the
   // block is idle while registers change.
   task automatic write_csr(cds_pkg::csr_index_type idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      scoreboard.write_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Writes all four registers. The unused upper bits of a period write carry
   // random values, which the block must ignore.
   task automatic apply_setting(logic [7:0] digit_p, logic [7:0] second_p,
                                logic [7:0] column_p, logic [63:0] image);
      write_csr(cds_pkg::CSR_DIGIT_PERIOD,   {32'($urandom), 24'($urandom), digit_p});
      write_csr(cds_pkg::CSR_SECOND_PERIOD,  {32'($urandom), 24'($urandom), second_p});
      write_csr(cds_pkg::CSR_COLUMN_PERIOD,  {32'($urandom), 24'($urandom), column_p});
      write_csr(cds_pkg::CSR_MATRIX_PATTERN, image);
      settings_used++;
   endtask

   // Mostly short periods so that the scans fire often, with both extremes.
   function automatic logic [7:0] pick_period();
      case ($urandom_range(0, 7))
         0:       return 8'd1;
         1:       return 8'd255;
         default: return 8'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [63:0] pick_image();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int p;
      int n;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. First a few beats with the reset settings: the pins
      // start cleared and a beat without a tick must repeat them.
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();

      // Period one on every divider with a fully set image: within these beats
      // only the old column countdown reloads, so only the column scan fires;
      // the digit and second countdowns are still on their reset periods.
      apply_setting(8'd1, 8'd1, 8'd1, '1);
      for (n = 0; n < 8; n++) begin
         send_tick(n != 2);
      end
      wait_idle();

      // Period zero must behave as period one; the image is cleared.
      apply_setting(8'd0, 8'd0, 8'd0, '0);
      for (n = 0; n < 8; n++) begin
         send_tick(n != 5);
      end
      wait_idle();

      // Random part: each phase takes a new setting, the first two at the
      // extremes, then runs random ticks with idle stretches switched
      // on or off at random every forty beats.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       apply_setting(8'd1, 8'd1, 8'd1, {$urandom, $urandom});
            1:       apply_setting(8'd255, 8'd255, 8'd255, '1);
            default: apply_setting(pick_period(), pick_period(), pick_period(), pick_image());
         endcase
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (n % 40 == 0) begin
               idle_on = ($urandom_range(0, 3) != 0);
            end
            send_tick($urandom_range(0, 3) != 0);
         end
         wait_idle();
      end

      // Fast run without idling: one second per tick carries the clock through
      // minute rollovers, while the scans keep cycling on short periods.
      idle_on = 1'b0;
      apply_setting(8'($urandom_range(1, 5)), 8'd1, 8'($urandom_range(1, 5)), pick_image());
      for (n = 0; n < FAST_BEATS; n++) begin
         send_tick($urandom_range(0, 15) != 0);
      end
      wait_idle();

      $display("Run covered %0d response beats from %0d ticks under %0d register settings.",
               scoreboard.beats_checked, ticks_sent, settings_used);
      $display("The clock passed midnight %0d time(s) and ended at %0d:%0d:%0d.",
               scoreboard.midnights, scoreboard.hours, scoreboard.minutes,
               scoreboard.seconds);
      if (scoreboard.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog, set far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("Timeout: the run did not finish in time.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
